[hdl/lfdc_pkg.sv]
// Package for the line-follow drive controller: mode and alarm codes, register
// indexes, limits and the shared control structs. No dependencies.
package lfdc_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_FOLLOW = 2'd1,
      MODE_PARKED = 2'd2
   } mode_type;

   localparam logic [1:0] ALARM_NONE  = 2'd0;
   localparam logic [1:0] ALARM_START = 2'd1;
   localparam logic [1:0] ALARM_STOP  = 2'd2;

   localparam logic [1:0] CSR_CRUISE      = 2'd0;
   localparam logic [1:0] CSR_WHITE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd2;

   localparam logic [6:0]  CRUISE_RST      = 7'd45;
   localparam logic [7:0]  WHITE_LIMIT_RST = 8'd3;
   localparam logic [15:0] TIMEOUT_RST     = 16'd300;

   localparam logic [7:0]  ALL_WHITE   = 8'hFF;
   localparam logic [7:0]  RUN_MAX     = 8'hFF;
   localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

   // 1/200 as a 20-bit fraction, exact for magnitudes up to 30000
   localparam logic [27:0] RECIP_200   = 28'd5243;

   typedef struct packed {
      logic [6:0]  cruise;
      logic [7:0]  white_limit;
      logic [15:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic       upd;
      logic       zero_drive;
      logic [1:0] alarm;
      mode_type   mode;
   } ctrl_type;

endpackage

[hdl/line_follow_drive_controller.sv]
// Top level of the line-follow drive controller: config registers, handshake
// and the two-stage pipeline. Depends on lfdc_pkg, lfdc_pi_lane, lfdc_mode_fsm
// and lfdc_merge.
//
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_ready   line_bits, steer_bias, left/right_pulses
//  rsp_     out        rsp_valid/rsp_ready   drive_update, left/right_drive,
//                                            alarm_code, mode_now
//  csr_     in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One tick per cycle sustained while the result side is ready. An accepted tick
// is registered in stage 1, which forms targets, errors, integrals and the
// next mode, then in stage 2 (the merge register), which forms the drives.
// Synchronous reset puts the mode in idle, clears counters and integrals, and
// loads the register defaults. A stalled result holds; the input side keeps
// taking ticks while stage 1 is empty. csr_ready is always high.
module line_follow_drive_controller import lfdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_line_bits,
   input  logic signed [11:0] req_steer_bias,
   input  logic signed [15:0] req_left_pulses,
   input  logic signed [15:0] req_right_pulses,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_drive_update,
   output logic signed [7:0] rsp_left_drive,
   output logic signed [7:0] rsp_right_drive,
   output logic [1:0]        rsp_alarm_code,
   output logic [1:0]        rsp_mode_now,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   cfg_type            cfg_ff;
   logic               s1_valid_ff;
   logic               advance;
   logic               accept;
   logic               integ_en;
   ctrl_type           s1_ctrl;
   logic signed [12:0] b16;
   logic signed [12:0] bias13;
   logic signed [12:0] left_sum, right_sum;
   logic signed [7:0]  left_raw, right_raw;

   assign csr_ready = 1'b1;

   // Register writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise      <= CRUISE_RST;
         cfg_ff.white_limit <= WHITE_LIMIT_RST;
         cfg_ff.timeout     <= TIMEOUT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CRUISE:      cfg_ff.cruise      <= csr_wdata[6:0];
            CSR_WHITE_LIMIT: cfg_ff.white_limit <= csr_wdata[7:0];
            CSR_TIMEOUT:     cfg_ff.timeout     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the pipeline whenever the result register is free or drains
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance || !s1_valid_ff;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Steering sums in 1/16 percent: base plus bias for left, minus for right
   assign b16       = {2'b00, cfg_ff.cruise, 4'b0000};
   assign bias13    = {req_steer_bias[11], req_steer_bias};
   assign left_sum  = b16 + bias13;
   assign right_sum = b16 - bias13;

   lfdc_mode_fsm u_mode (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .line_bits (req_line_bits),
      .cfg       (cfg_ff),
      .integ_en  (integ_en),
      .ctrl_ff   (s1_ctrl)
   );

   lfdc_pi_lane u_left (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .integ_en  (integ_en),
      .steer_sum (left_sum),
      .pulses    (req_left_pulses),
      .drive     (left_raw)
   );

   lfdc_pi_lane u_right (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .integ_en  (integ_en),
      .steer_sum (right_sum),
      .pulses    (req_right_pulses),
      .drive     (right_raw)
   );

   lfdc_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .stage_valid      (s1_valid_ff),
      .ctrl             (s1_ctrl),
      .left_raw         (left_raw),
      .right_raw        (right_raw),
      .rsp_valid        (rsp_valid),
      .rsp_drive_update (rsp_drive_update),
      .rsp_left_drive   (rsp_left_drive),
      .rsp_right_drive  (rsp_right_drive),
      .rsp_alarm_code   (rsp_alarm_code),
      .rsp_mode_now     (rsp_mode_now)
   );

   // An empty result register always lets a tick in
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // A result that ends in idle never carries a nonzero command
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode_now == MODE_IDLE) |->
         (rsp_left_drive == 8'sd0 && rsp_right_drive == 8'sd0))
      else $error("nonzero drive in idle result");

   // The stop-zone alarm comes only with a parked, zero command
   a_stop_parks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alarm_code == ALARM_STOP) |->
         (rsp_mode_now == MODE_PARKED && rsp_drive_update &&
          rsp_left_drive == 8'sd0 && rsp_right_drive == 8'sd0))
      else $error("stop alarm without parked zero command");

   // Drives stay inside the percent limits
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_drive <= 8'sd100 && rsp_left_drive >= -8'sd100 &&
                     rsp_right_drive <= 8'sd100 && rsp_right_drive >= -8'sd100))
      else $error("drive outside limits");

endmodule

[hdl/lfdc_pi_lane.sv]
// One wheel lane: target from the steering sum, PI integral (state) and drive.
// Depends on lfdc_pkg.
module lfdc_pi_lane import lfdc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               integ_en,
   input  logic signed [12:0] steer_sum,
   input  logic signed [15:0] pulses,
   output logic signed [7:0]  drive
);

   logic signed [12:0] rounded;
   logic signed [8:0]  quot;
   logic signed [7:0]  target;
   logic signed [16:0] err;
   logic signed [17:0] integ_sum;
   logic signed [13:0] integ_clamped;
   logic signed [13:0] integ_ff, integ_in;
   logic signed [7:0]  target_ff;
   logic signed [16:0] err_ff;
   logic signed [26:0] e27;
   logic signed [26:0] adj_sum;
   logic signed [14:0] adj;
   logic signed [15:0] t16;
   logic signed [15:0] cmd_sum;
   logic signed [15:0] cmd_neg;
   logic        [14:0] cmd_mag;
   logic        [27:0] prod;
   logic        [7:0]  q_mag;
   logic signed [8:0]  q_signed;

   // Stage 1: truncate toward zero by 16, clamp, error and integral
   always_comb begin
      rounded = steer_sum[12] ? steer_sum + 13'sd15 : steer_sum;
      quot    = rounded[12:4];
      if (quot > 9'sd100) begin
         target = 8'sd100;
      end else if (quot < -9'sd100) begin
         target = -8'sd100;
      end else begin
         target = quot[7:0];
      end
      err       = {{9{target[7]}}, target} - {pulses[15], pulses};
      integ_sum = {{4{integ_ff[13]}}, integ_ff} + {err[16], err};
      if (integ_sum > 18'sd5000) begin
         integ_clamped = 14'sd5000;
      end else if (integ_sum < -18'sd5000) begin
         integ_clamped = -14'sd5000;
      end else begin
         integ_clamped = integ_sum[13:0];
      end
      integ_in = integ_en ? integ_clamped : integ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (load) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         target_ff <= target;
         err_ff    <= err;
      end
   end

   // Stage 2: integ_ff already holds the integral of the staged item, since
   // nothing new is loaded while that item waits here.
   always_comb begin
      e27     = {{10{err_ff[16]}}, err_ff};
      adj_sum = (e27 <<< 8) + (e27 <<< 7) + (e27 <<< 4)
              + {{13{integ_ff[13]}}, integ_ff};
      if (adj_sum > 27'sd10000) begin
         adj = 15'sd10000;
      end else if (adj_sum < -27'sd10000) begin
         adj = -15'sd10000;
      end else begin
         adj = adj_sum[14:0];
      end
      t16      = {{8{target_ff[7]}}, target_ff};
      cmd_sum  = (t16 <<< 7) + (t16 <<< 6) + (t16 <<< 3) + {adj[14], adj};
      cmd_neg  = -cmd_sum;
      cmd_mag  = cmd_sum[15] ? cmd_neg[14:0] : cmd_sum[14:0];
      prod     = {13'd0, cmd_mag} * RECIP_200;
      q_mag    = prod[27:20];
      q_signed = cmd_sum[15] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
      if (q_signed > 9'sd100) begin
         drive = 8'sd100;
      end else if (q_signed < -9'sd100) begin
         drive = -8'sd100;
      end else begin
         drive = q_signed[7:0];
      end
   end

endmodule

[hdl/lfdc_mode_fsm.sv]
// Mode sequencer: idle, following, parked, with tick and white-run counters.
// Depends on lfdc_pkg.
module lfdc_mode_fsm import lfdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] line_bits,
   input  cfg_type    cfg,
   output logic       integ_en,
   output ctrl_type   ctrl_ff
);

   mode_type    mode_ff, mode_in;
   mode_type    prev_ff;
   logic [15:0] ticks_ff, ticks_in, ticks_base;
   logic [7:0]  white_ff, white_in, white_next;
   ctrl_type    ctrl_in;
   logic        parked;

   assign integ_en = load && (mode_ff == MODE_FOLLOW);

   always_comb begin
      ticks_base = (mode_ff != prev_ff) ? 16'd0 : ticks_ff;
      ticks_in   = (ticks_base < TICKS_MAX) ? ticks_base + 16'd1 : ticks_base;
      white_next = (white_ff < RUN_MAX) ? white_ff + 8'd1 : white_ff;
      white_in   = white_ff;
      mode_in    = mode_ff;
      parked     = 1'b0;
      ctrl_in    = '{upd: 1'b0, zero_drive: 1'b1, alarm: ALARM_NONE, mode: mode_ff};
      unique case (mode_ff)
         MODE_IDLE: begin
            if (line_bits != 8'd0) begin
               mode_in       = MODE_FOLLOW;
               ctrl_in.alarm = ALARM_START;
            end
         end
         MODE_FOLLOW: begin
            ctrl_in.upd        = 1'b1;
            ctrl_in.zero_drive = 1'b0;
            if (line_bits == ALL_WHITE) begin
               white_in = white_next;
               if (white_next >= cfg.white_limit) begin
                  white_in           = 8'd0;
                  ticks_in           = 16'd0;
                  mode_in            = MODE_PARKED;
                  ctrl_in.zero_drive = 1'b1;
                  ctrl_in.alarm      = ALARM_STOP;
                  parked             = 1'b1;
               end
            end else begin
               white_in = 8'd0;
            end
            if (!parked && ticks_in > cfg.timeout) begin
               ticks_in           = 16'd0;
               mode_in            = MODE_IDLE;
               ctrl_in.zero_drive = 1'b1;
            end
         end
         default: begin
            ctrl_in.upd = 1'b1;
            if (ticks_in > cfg.timeout) begin
               ticks_in = 16'd0;
               mode_in  = MODE_IDLE;
            end
         end
      endcase
      ctrl_in.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         prev_ff  <= MODE_IDLE;
         ticks_ff <= '0;
         white_ff <= '0;
      end else if (load) begin
         mode_ff  <= mode_in;
         prev_ff  <= mode_ff;
         ticks_ff <= ticks_in;
         white_ff <= white_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff <= ctrl_in;
      end
   end

endmodule

[hdl/lfdc_merge.sv]
// Merge stage: combines both lane drives with the mode control into the
// registered result. Depends on lfdc_pkg.
module lfdc_merge import lfdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              stage_valid,
   input  ctrl_type          ctrl,
   input  logic signed [7:0] left_raw,
   input  logic signed [7:0] right_raw,
   output logic              rsp_valid,
   output logic              rsp_drive_update,
   output logic signed [7:0] rsp_left_drive,
   output logic signed [7:0] rsp_right_drive,
   output logic [1:0]        rsp_alarm_code,
   output logic [1:0]        rsp_mode_now
);

   logic valid_ff;

   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   // Force zero drive when the tick parks, times out, idles or sits parked
   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         rsp_drive_update <= ctrl.upd;
         rsp_left_drive   <= ctrl.zero_drive ? 8'sd0 : left_raw;
         rsp_right_drive  <= ctrl.zero_drive ? 8'sd0 : right_raw;
         rsp_alarm_code   <= ctrl.alarm;
         rsp_mode_now     <= ctrl.mode;
      end
   end

endmodule

[sim/tb.sv]
// Self-checking bench for line_follow_drive_controller: random and directed sensor
// ticks, per-tick prediction of the drive command, field-by-field compare.
// Depends on lfdc_pkg and the controller RTL only.
module tb import lfdc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Controller limits: drive percent, integral in hundredths, adjustment in 1/200
   localparam int DRIVE_LIM = 100;
   localparam int INTEG_LIM = 5000;
   localparam int ADJ_LIM   = 10000;

   // Index with no register behind it; a write there must change nothing
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 300;   // results seen before the long receiver stall
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_WAIT  = 8;
   localparam int MAX_PRINTS  = 40;

   typedef struct {
      logic [7:0]         line_bits;
      logic signed [11:0] steer_bias;
      logic signed [15:0] left_pulses;
      logic signed [15:0] right_pulses;
   } sensor_tick_type;

   typedef struct {
      logic       upd;
      logic [7:0] left_drive;
      logic [7:0] right_drive;
      logic [1:0] alarm;
      mode_type   mode;
   } drive_cmd_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_line_bits = '0;
   logic signed [11:0] req_steer_bias = '0;
   logic signed [15:0] req_left_pulses = '0;
   logic signed [15:0] req_right_pulses = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_drive_update;
   logic signed [7:0]  rsp_left_drive;
   logic signed [7:0]  rsp_right_drive;
   logic [1:0]         rsp_alarm_code;
   logic [1:0]         rsp_mode_now;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   line_follow_drive_controller DUT (.*);

   // ---------------------------------------------------------------------
   // Predictor state: register shadows and the controller's own state
   // ---------------------------------------------------------------------
   int cfg_base    = int'(CRUISE_RST);
   int cfg_stop    = int'(WHITE_LIMIT_RST);
   int cfg_timeout = int'(TIMEOUT_RST);

   mode_type ctl_mode      = MODE_IDLE;
   mode_type ctl_prev_mode = MODE_IDLE;
   int       ctl_ticks     = 0;
   int       white_run     = 0;
   int       left_integ    = 0;
   int       right_integ   = 0;

   sensor_tick_type pending_ticks[$];
   drive_cmd_type   expected_cmds[$];
   sensor_tick_type on_wire;

   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  steady_flow = 1'b1;   // no idling on either side while set
   int  results_checked = 0;
   int  ticks_sent = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   int  phases_run = 0;
   int  n_start = 0;
   int  n_stop_zone = 0;
   int  n_follow_timeout = 0;
   int  n_park_timeout = 0;

   function automatic int clamp_mag(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Drive from target, speed error and the already updated integral
   function automatic int pi_drive(int target, int err, int integ);
      int adj;
      adj = clamp_mag(400 * err + integ, ADJ_LIM);
      return clamp_mag((200 * target + adj) / 200, DRIVE_LIM);
   endfunction

   // Advance the controller by one accepted tick and queue the command it issues
   function automatic void step_controller(input sensor_tick_type t);
      drive_cmd_type cmd;
      int  lt, rt, lerr, rerr, ld, rd;
      bit  parked;
      ld = 0;
      rd = 0;
      parked = 1'b0;
      cmd.upd = 1'b0;
      cmd.alarm = ALARM_NONE;
      // a mode change is seen one tick late: the counter restarts there
      if (ctl_mode != ctl_prev_mode) begin
         ctl_prev_mode = ctl_mode;
         ctl_ticks = 0;
      end
      if (ctl_ticks < int'(TICKS_MAX)) ctl_ticks++;
      case (ctl_mode)
         MODE_IDLE: begin
            if (t.line_bits != 8'h00) begin
               ctl_mode = MODE_FOLLOW;
               cmd.alarm = ALARM_START;
               n_start++;
            end
         end
         MODE_FOLLOW: begin
            lt = clamp_mag((16 * cfg_base + int'(t.steer_bias)) / 16, DRIVE_LIM);
            rt = clamp_mag((16 * cfg_base - int'(t.steer_bias)) / 16, DRIVE_LIM);
            lerr = lt - int'(t.left_pulses);
            rerr = rt - int'(t.right_pulses);
            left_integ = clamp_mag(left_integ + lerr, INTEG_LIM);
            right_integ = clamp_mag(right_integ + rerr, INTEG_LIM);
            ld = pi_drive(lt, lerr, left_integ);
            rd = pi_drive(rt, rerr, right_integ);
            cmd.upd = 1'b1;
            if (t.line_bits == ALL_WHITE) begin
               if (white_run < int'(RUN_MAX)) white_run++;
               if (white_run >= cfg_stop) begin
                  white_run = 0;
                  ctl_ticks = 0;
                  ctl_mode = MODE_PARKED;
                  ld = 0;
                  rd = 0;
                  cmd.alarm = ALARM_STOP;
                  parked = 1'b1;
                  n_stop_zone++;
               end
            end else begin
               white_run = 0;
            end
            // the stop zone skips the timeout check; white_run survives a timeout
            if (!parked && ctl_ticks > cfg_timeout) begin
               ctl_ticks = 0;
               ctl_mode = MODE_IDLE;
               ld = 0;
               rd = 0;
               n_follow_timeout++;
            end
         end
         default: begin
            cmd.upd = 1'b1;
            if (ctl_ticks > cfg_timeout) begin
               ctl_ticks = 0;
               ctl_mode = MODE_IDLE;
               n_park_timeout++;
            end
         end
      endcase
      cmd.left_drive = ld[7:0];
      cmd.right_drive = rd[7:0];
      cmd.mode = ctl_mode;
      expected_cmds.push_back(cmd);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly near the wheel targets so the loop is not always saturated
   function automatic logic signed [15:0] rand_pulses();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 16'($urandom_range(0, 240) - 120);
      if (pick < 90) return 16'($urandom);
      return pick[0] ? 16'sh7FFF : 16'sh8000;
   endfunction

   function automatic sensor_tick_type random_tick();
      sensor_tick_type t;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) t.line_bits = 8'h00;
      else if (pick < 20) t.line_bits = ALL_WHITE;
      else t.line_bits = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 70) t.steer_bias = 12'($urandom_range(0, 1600) - 800);
      else if (pick < 90) t.steer_bias = 12'($urandom);
      else t.steer_bias = pick[0] ? 12'sh7FF : 12'sh800;
      t.left_pulses = rand_pulses();
      t.right_pulses = rand_pulses();
      return t;
   endfunction

   function automatic void add_tick(logic [7:0] line, logic signed [11:0] bias,
                                    logic signed [15:0] lp, logic signed [15:0] rp);
      sensor_tick_type t;
      t.line_bits = line;
      t.steer_bias = bias;
      t.left_pulses = lp;
      t.right_pulses = rp;
      pending_ticks.push_back(t);
   endfunction

   // Random ticks with all-white bursts so stop zones and broken runs both occur
   function automatic void queue_random_ticks(int count);
      sensor_tick_type t;
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         t = random_tick();
         if (burst > 0) begin
            t.line_bits = ALL_WHITE;
            burst--;
         end else if ($urandom_range(0, 99) < 8) begin
            burst = $urandom_range(1, (cfg_stop > 8) ? 10 : cfg_stop + 2);
         end
         pending_ticks.push_back(t);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH: %s", msg);
   endtask

   // Sender pauses here until every expected command has come back
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || expected_cmds.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CRUISE:      cfg_base = int'(data[6:0]);
         CSR_WHITE_LIMIT: cfg_stop = int'(data[7:0]);
         CSR_TIMEOUT:     cfg_timeout = int'(data);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic start_phase(input logic [15:0] base, input logic [15:0] stop,
                              input logic [15:0] limit, input bit quiet);
      write_reg(CSR_CRUISE, base);
      write_reg(CSR_WHITE_LIMIT, stop);
      write_reg(CSR_TIMEOUT, limit);
      steady_flow <= quiet;
      phases_run++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present queued ticks, predict each one as its transfer completes
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : tick_driver
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            step_controller(on_wire);
            ticks_sent++;
         end
         if (req_valid && !req_ready) begin
            // hold the offered tick until it is taken
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            on_wire = pending_ticks.pop_front();
            req_line_bits <= on_wire.line_bits;
            req_steer_bias <= on_wire.steer_bias;
            req_left_pulses <= on_wire.left_pulses;
            req_right_pulses <= on_wire.right_pulses;
            req_valid <= 1'b1;
            send_gap <= steady_flow ? 0 : gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each command transfer with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : cmd_monitor
      drive_cmd_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               report_mismatch("command transfer with no tick outstanding");
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_drive_update !== want.upd)
                  report_mismatch($sformatf("cmd %0d drive_update got %b want %b",
                     results_checked, rsp_drive_update, want.upd));
               if (rsp_left_drive !== want.left_drive)
                  report_mismatch($sformatf("cmd %0d left_drive got %0d want %0d",
                     results_checked, rsp_left_drive, $signed(want.left_drive)));
               if (rsp_right_drive !== want.right_drive)
                  report_mismatch($sformatf("cmd %0d right_drive got %0d want %0d",
                     results_checked, rsp_right_drive, $signed(want.right_drive)));
               if (rsp_alarm_code !== want.alarm)
                  report_mismatch($sformatf("cmd %0d alarm_code got %0d want %0d",
                     results_checked, rsp_alarm_code, want.alarm));
               if (rsp_mode_now !== want.mode)
                  report_mismatch($sformatf("cmd %0d mode_now got %0d want %0d",
                     results_checked, rsp_mode_now, want.mode));
            end
            results_checked <= results_checked + 1;
         end
         // drop ready for the long stall, else for short random stalls
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) recv_gap <= gap_len();
         end
      end
   end

   // One long receiver stall while ticks keep coming: the pipeline must back up
   always @(posedge clock) begin : rsp_long_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog: no completion within %0d cycles", CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : sequencer
      sensor_tick_type t;

      // Directed ticks under the reset settings (base 45, stop after 3, limit 300)
      add_tick(8'h00, 12'sh7FF, 16'sh7FFF, 16'sh8000);   // idle, no line: stay idle
      add_tick(8'h00, 12'sh800, 16'sh8000, 16'sh7FFF);
      add_tick(8'h01, 12'sh000, 16'sh0000, 16'sh0000);   // start alarm
      add_tick(8'h80, 12'sh000, 16'sd45, 16'sd45);       // on target
      add_tick(8'h18, 12'sh7FF, 16'sh7FFF, 16'sh8000);   // every clamp hit
      add_tick(8'h18, 12'sh800, 16'sh8000, 16'sh7FFF);
      add_tick(8'h3C, 12'shFFF, 16'sh0000, 16'sh0000);   // bias -1/16 truncates the left target to 44
      add_tick(8'h3C, 12'sd17, 16'sd44, 16'sd46);
      add_tick(8'hAA, 12'sd800, 16'sd95, -16'sd5);
      add_tick(ALL_WHITE, 12'sh000, 16'sd45, 16'sd45);   // white run broken before stop
      add_tick(ALL_WHITE, 12'sh000, 16'sd45, 16'sd45);
      add_tick(8'h7F, 12'sh000, 16'sd45, 16'sd45);
      add_tick(ALL_WHITE, -12'sd300, 16'sd30, 16'sd60);
      add_tick(ALL_WHITE, -12'sd300, 16'sd30, 16'sd60);
      add_tick(ALL_WHITE, -12'sd300, 16'sd30, 16'sd60);  // stop zone: park
      add_tick(ALL_WHITE, 12'sh000, 16'sh7FFF, 16'sh8000);
      add_tick(8'h00, 12'sh7FF, 16'sh0000, 16'sh0000);
      add_tick(8'h55, 12'sh800, -16'sd1, 16'sd1);
      add_tick(8'hFE, 12'sd5, 16'sd10, -16'sd10);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      write_reg(CSR_UNUSED, 16'($urandom));

      // Fastest parking and short limits: park timeouts come often
      start_phase(16'd100, 16'd1, 16'd20, 1'b0);
      queue_random_ticks(130);
      wait_drained();

      // All zero: parks on the first white tick, follow and park modes time out at once
      start_phase(16'd0, 16'd0, 16'd0, 1'b0);
      queue_random_ticks(100);
      add_tick(8'h00, 12'sh000, 16'sh0000, 16'sh0000);   // leaves the controller idle
      wait_drained();

      // All ones: longest white run to park, and a limit that never expires
      start_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_tick(8'h01, 12'sh000, 16'sh0000, 16'sh0000);
      for (int i = 0; i < 256; i++) begin
         t = random_tick();
         add_tick(ALL_WHITE, t.steer_bias, t.left_pulses, t.right_pulses);
      end
      queue_random_ticks(60);
      wait_drained();

      // Back-to-back transfers with the shortest nonzero limit
      start_phase(16'd60, 16'd3, 16'd1, 1'b1);
      queue_random_ticks(110);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         start_phase(16'($urandom_range(0, 127)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(3, 60)), 1'b0);
         queue_random_ticks(110);
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("coverage: %0d ticks, %0d commands checked over %0d register settings",
               ticks_sent, results_checked, phases_run + 1);
      $display("coverage: %0d starts, %0d stop zones, %0d follow timeouts, %0d park timeouts",
               n_start, n_stop_zone, n_follow_timeout, n_park_timeout);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
